FILE: rtl/core/shs_pkg.sv
// Shared types, codes and constants of the stepper command and homing supervisor.
package shs_pkg;

    localparam int INTERVAL_W = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [INTERVAL_W-1:0] HOMING_INTERVAL_RST  = 32'd16276;
    localparam logic                  HOMING_DIRECTION_RST = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOMING_INTERVAL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOMING_DIRECTION = 8'd1;

    typedef enum logic [2:0] {
        MODE_NONE      = 3'd0,
        MODE_SET_SPEED = 3'd1,
        MODE_ENABLE    = 3'd2,
        MODE_ESTOP     = 3'd3,
        MODE_HOME      = 3'd4,
        MODE_ACK       = 3'd5,
        MODE_RESET_CNT = 3'd6,
        MODE_UNKNOWN   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        SEL_SPINDLE = 2'd0,
        SEL_LATERAL = 2'd1,
        SEL_BOTH    = 2'd2,
        SEL_NONE    = 2'd3
    } axis_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_HOME    = 2'd1,
        EV_ENDSTOP = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        CLR_NONE    = 2'd0,
        CLR_LATERAL = 2'd1,
        CLR_ALL     = 2'd2
    } clear_t;

    typedef struct packed {
        logic [2:0]            mode;
        logic [INTERVAL_W-1:0] spindle_interval_target;
        logic [INTERVAL_W-1:0] lateral_interval_target;
        logic                  spindle_dir_target;
        logic                  lateral_dir_target;
        logic                  enable_value;
        logic [1:0]            axis_select;
        logic [1:0]            endstop_bits;
        logic                  spindle_fault;
        logic                  lateral_fault;
        logic                  lateral_endstop_fault;
        logic                  publish;
    } cmd_item_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] spindle_interval;
        logic [INTERVAL_W-1:0] lateral_interval;
        logic                  spindle_dir;
        logic                  lateral_dir;
        logic                  spindle_enable;
        logic                  lateral_enable;
        logic                  spindle_run;
        logic                  lateral_run;
        logic [2:0]            acked_command;
        logic [3:0]            state_flags;
        logic [1:0]            event_code;
        logic [1:0]            clear_counters;
    } result_item_t;

endpackage

FILE: rtl/core/shs_channels.sv
// Handshake channel interfaces: command input, result output and configuration write.
interface shs_cmd_if
    import shs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [2:0]            mode;
    logic [INTERVAL_W-1:0] spindle_interval_target;
    logic [INTERVAL_W-1:0] lateral_interval_target;
    logic                  spindle_dir_target;
    logic                  lateral_dir_target;
    logic                  enable_value;
    logic [1:0]            axis_select;
    logic [1:0]            endstop_bits;
    logic                  spindle_fault;
    logic                  lateral_fault;
    logic                  lateral_endstop_fault;
    logic                  publish;

    modport source (
        output valid, mode, spindle_interval_target, lateral_interval_target,
               spindle_dir_target, lateral_dir_target, enable_value, axis_select,
               endstop_bits, spindle_fault, lateral_fault, lateral_endstop_fault,
               publish,
        input  ready
    );
    modport sink (
        input  valid, mode, spindle_interval_target, lateral_interval_target,
               spindle_dir_target, lateral_dir_target, enable_value, axis_select,
               endstop_bits, spindle_fault, lateral_fault, lateral_endstop_fault,
               publish,
        output ready
    );
endinterface

interface shs_result_if
    import shs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] spindle_interval;
    logic [INTERVAL_W-1:0] lateral_interval;
    logic                  spindle_dir;
    logic                  lateral_dir;
    logic                  spindle_enable;
    logic                  lateral_enable;
    logic                  spindle_run;
    logic                  lateral_run;
    logic [2:0]            acked_command;
    logic [3:0]            state_flags;
    logic [1:0]            event_code;
    logic [1:0]            clear_counters;

    modport source (
        output valid, spindle_interval, lateral_interval, spindle_dir, lateral_dir,
               spindle_enable, lateral_enable, spindle_run, lateral_run,
               acked_command, state_flags, event_code, clear_counters,
        input  ready
    );
    modport sink (
        input  valid, spindle_interval, lateral_interval, spindle_dir, lateral_dir,
               spindle_enable, lateral_enable, spindle_run, lateral_run,
               acked_command, state_flags, event_code, clear_counters,
        output ready
    );
endinterface

interface shs_cfg_if
    import shs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/stepper_command_homing_supervisor_top.sv
// Stepper command and homing supervisor: one command period per transaction.
// A command lands in the input register at the accepting edge; its result is then
// loaded into the result register once the result slot is free, and offered from there.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset: asynchronous, active low; clears all axis state, homing and events, and
// loads the homing interval and direction registers with their defaults.
module stepper_command_homing_supervisor_top
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    shs_cmd_if.sink           cmd,
    shs_result_if.source      result,
    shs_cfg_if.sink           cfg
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_APPROACH = 2'd1,
        PH_HIT      = 2'd2,
        PH_SPARE    = 2'd3
    } phase_t;

    // Configuration registers
    logic [INTERVAL_W-1:0] homing_interval_reg;
    logic                  homing_direction_reg;

    // Pipeline registers
    logic         in_valid_reg;
    cmd_item_t    in_item_reg;
    logic         out_valid_reg;
    result_item_t out_item_reg;

    // Supervisor state
    phase_t                phase_reg,           phase_next;
    logic [INTERVAL_W-1:0] saved_interval_reg,  saved_interval_next;
    logic                  saved_dir_reg,       saved_dir_next;
    logic [INTERVAL_W-1:0] spindle_int_reg,     spindle_int_next;
    logic [INTERVAL_W-1:0] lateral_int_reg,     lateral_int_next;
    logic [1:0]            dir_reg,             dir_next;
    logic [1:0]            enable_reg,          enable_next;
    logic [1:0]            run_reg,             run_next;
    event_t                event_reg,           event_next;
    result_item_t          out_item_next;

    logic      out_free;
    logic      advance;
    cmd_item_t cmd_item;

    assign cfg.ready = 1'b1;

    // Hand over from input register when the result slot is empty or being drained
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;

    assign cmd_item = '{
        mode:                    cmd.mode,
        spindle_interval_target: cmd.spindle_interval_target,
        lateral_interval_target: cmd.lateral_interval_target,
        spindle_dir_target:      cmd.spindle_dir_target,
        lateral_dir_target:      cmd.lateral_dir_target,
        enable_value:            cmd.enable_value,
        axis_select:             cmd.axis_select,
        endstop_bits:            cmd.endstop_bits,
        spindle_fault:           cmd.spindle_fault,
        lateral_fault:           cmd.lateral_fault,
        lateral_endstop_fault:   cmd.lateral_endstop_fault,
        publish:                 cmd.publish
    };

    // Handle the command, step the homing machine, then build the status
    always_comb
    begin
        logic   sp_f;
        logic   lat_f;
        logic   lat_es_f;
        clear_t clr;
        logic [3:0] flags;

        phase_next          = phase_reg;
        saved_interval_next = saved_interval_reg;
        saved_dir_next      = saved_dir_reg;
        spindle_int_next    = spindle_int_reg;
        lateral_int_next    = lateral_int_reg;
        dir_next            = dir_reg;
        enable_next         = enable_reg;
        run_next            = run_reg;
        event_next          = event_reg;
        sp_f                = in_item_reg.spindle_fault;
        lat_f               = in_item_reg.lateral_fault;
        lat_es_f            = in_item_reg.lateral_endstop_fault;
        clr                 = CLR_NONE;
        flags               = 4'd0;

        case (mode_t'(in_item_reg.mode))
            MODE_SET_SPEED:
            begin
                spindle_int_next = in_item_reg.spindle_interval_target;
                lateral_int_next = in_item_reg.lateral_interval_target;
                dir_next = {in_item_reg.lateral_dir_target, in_item_reg.spindle_dir_target};
                if (in_item_reg.spindle_interval_target == '0)
                    run_next[0] = 1'b0;
                else if (enable_reg[0])
                    run_next[0] = 1'b1;
                if (in_item_reg.lateral_interval_target == '0)
                    run_next[1] = 1'b0;
                else if (enable_reg[1])
                    run_next[1] = 1'b1;
            end
            MODE_ENABLE:
            begin
                if (in_item_reg.axis_select inside {SEL_SPINDLE, SEL_BOTH})
                begin
                    enable_next[0] = in_item_reg.enable_value;
                    if (!in_item_reg.enable_value)
                        run_next[0] = 1'b0;
                end
                if (in_item_reg.axis_select inside {SEL_LATERAL, SEL_BOTH})
                begin
                    enable_next[1] = in_item_reg.enable_value;
                    if (!in_item_reg.enable_value)
                        run_next[1] = 1'b0;
                end
            end
            MODE_ESTOP:
            begin
                run_next         = 2'b00;
                enable_next      = 2'b00;
                spindle_int_next = '0;
                lateral_int_next = '0;
                phase_next       = PH_IDLE;
            end
            MODE_HOME:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    saved_interval_next = lateral_int_reg;
                    saved_dir_next      = dir_reg[1];
                    lateral_int_next    = homing_interval_reg;
                    dir_next[1]         = homing_direction_reg;
                    enable_next[1]      = 1'b1;
                    run_next            = 2'b10;
                    phase_next          = PH_APPROACH;
                end
            end
            MODE_ACK:
                event_next = EV_NONE;
            MODE_RESET_CNT:
            begin
                clr      = CLR_ALL;
                sp_f     = 1'b0;
                lat_f    = 1'b0;
                lat_es_f = 1'b0;
            end
            default:
                ;
        endcase

        // Advance homing
        case (phase_next)
            PH_APPROACH:
            begin
                if (in_item_reg.endstop_bits != 2'b00)
                begin
                    run_next[1] = 1'b0;
                    if (clr == CLR_NONE)
                        clr = CLR_LATERAL;
                    lat_f      = 1'b0;
                    lat_es_f   = 1'b0;
                    phase_next = PH_HIT;
                end
            end
            PH_HIT:
            begin
                lateral_int_next = saved_interval_next;
                dir_next[1]      = saved_dir_next;
                event_next       = EV_HOME;
                phase_next       = PH_IDLE;
            end
            PH_IDLE:
                ;
            default:
                phase_next = PH_IDLE;
        endcase

        // Publish status and raise an endstop event outside homing
        if (in_item_reg.publish)
        begin
            flags[0] = (phase_next != PH_IDLE);
            flags[1] = (run_next != 2'b00);
            flags[2] = (in_item_reg.endstop_bits != 2'b00);
            flags[3] = sp_f || lat_f;
            if (phase_next == PH_IDLE && lat_es_f && event_next == EV_NONE)
                event_next = EV_ENDSTOP;
        end

        out_item_next = '{
            spindle_interval: spindle_int_next,
            lateral_interval: lateral_int_next,
            spindle_dir:      dir_next[0],
            lateral_dir:      dir_next[1],
            spindle_enable:   enable_next[0],
            lateral_enable:   enable_next[1],
            spindle_run:      run_next[0],
            lateral_run:      run_next[1],
            acked_command:    in_item_reg.mode,
            state_flags:      flags,
            event_code:       event_next,
            clear_counters:   clr
        };
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_interval_reg  <= HOMING_INTERVAL_RST;
            homing_direction_reg <= HOMING_DIRECTION_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_HOMING_INTERVAL)
                homing_interval_reg <= cfg.data[INTERVAL_W-1:0];
            else if (cfg.index == CFG_HOMING_DIRECTION)
                homing_direction_reg <= cfg.data[0];
        end
    end

    // Capture command transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_item_reg <= cmd_item;
    end

    // Commit supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            saved_interval_reg <= '0;
            saved_dir_reg      <= 1'b0;
            spindle_int_reg    <= '0;
            lateral_int_reg    <= '0;
            dir_reg            <= 2'b00;
            enable_reg         <= 2'b00;
            run_reg            <= 2'b00;
            event_reg          <= EV_NONE;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            saved_interval_reg <= saved_interval_next;
            saved_dir_reg      <= saved_dir_next;
            spindle_int_reg    <= spindle_int_next;
            lateral_int_reg    <= lateral_int_next;
            dir_reg            <= dir_next;
            enable_reg         <= enable_next;
            run_reg            <= run_next;
            event_reg          <= event_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= out_item_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.spindle_interval = out_item_reg.spindle_interval;
    assign result.lateral_interval = out_item_reg.lateral_interval;
    assign result.spindle_dir      = out_item_reg.spindle_dir;
    assign result.lateral_dir      = out_item_reg.lateral_dir;
    assign result.spindle_enable   = out_item_reg.spindle_enable;
    assign result.lateral_enable   = out_item_reg.lateral_enable;
    assign result.spindle_run      = out_item_reg.spindle_run;
    assign result.lateral_run      = out_item_reg.lateral_run;
    assign result.acked_command    = out_item_reg.acked_command;
    assign result.state_flags      = out_item_reg.state_flags;
    assign result.event_code       = out_item_reg.event_code;
    assign result.clear_counters   = out_item_reg.clear_counters;

endmodule

FILE: tb/sv/homing_supervisor_checker.sv
`timescale 1ns / 100ps
// Checker: predicts every supervisor result from the observed transactions and compares.
module homing_supervisor_checker
    import shs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    shs_cmd_if    cmd,
    shs_result_if result,
    shs_cfg_if    cfg,
    output int    fail_count,
    output int    pending
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_APPROACH = 2'd1;
    localparam logic [1:0] PH_HIT      = 2'd2;
    localparam int         MAX_PRINTS  = 100;

    // Predicted copy of the configuration
    logic [INTERVAL_W-1:0] homing_int;
    logic                  home_dir_cfg;

    // Predicted copy of the axis and homing state; bit0 spindle, bit1 lateral
    logic [1:0]            phase;
    logic [INTERVAL_W-1:0] saved_int;
    logic                  saved_dir;
    logic [INTERVAL_W-1:0] spindle_int;
    logic [INTERVAL_W-1:0] lateral_int;
    logic [1:0]            dir_bits;
    logic [1:0]            en_bits;
    logic [1:0]            run_bits;
    event_t                pend_ev;

    result_item_t          expected_results[$];
    cmd_item_t             seen_cmd;
    result_item_t          seen_res;
    result_item_t          want_res;
    int                    n_fail = 0;
    int                    n_pending = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    // Work out one command period and advance the predicted state
    function automatic result_item_t predict_period(input cmd_item_t c);
        result_item_t r;
        clear_t       clr;
        axis_t        axis;
        logic         sp_fault;
        logic         lat_fault;
        logic         lat_es_fault;
        logic [3:0]   flags;
        clr          = CLR_NONE;
        axis         = axis_t'(c.axis_select);
        sp_fault     = c.spindle_fault;
        lat_fault    = c.lateral_fault;
        lat_es_fault = c.lateral_endstop_fault;
        flags        = 4'd0;

        // Handle the host command first
        case (mode_t'(c.mode))
            MODE_SET_SPEED:
            begin
                spindle_int = c.spindle_interval_target;
                lateral_int = c.lateral_interval_target;
                dir_bits    = {c.lateral_dir_target, c.spindle_dir_target};
                if (c.spindle_interval_target != '0 && en_bits[0])
                    run_bits[0] = 1'b1;
                if (c.lateral_interval_target != '0 && en_bits[1])
                    run_bits[1] = 1'b1;
                if (c.spindle_interval_target == '0)
                    run_bits[0] = 1'b0;
                if (c.lateral_interval_target == '0)
                    run_bits[1] = 1'b0;
            end
            MODE_ENABLE:
            begin
                if (axis == SEL_SPINDLE || axis == SEL_BOTH)
                begin
                    en_bits[0] = c.enable_value;
                    if (!c.enable_value)
                        run_bits[0] = 1'b0;
                end
                if (axis == SEL_LATERAL || axis == SEL_BOTH)
                begin
                    en_bits[1] = c.enable_value;
                    if (!c.enable_value)
                        run_bits[1] = 1'b0;
                end
            end
            MODE_ESTOP:
            begin
                run_bits    = 2'b00;
                en_bits     = 2'b00;
                spindle_int = '0;
                lateral_int = '0;
                phase       = PH_IDLE;
            end
            MODE_HOME:
            begin
                // Ignore a second start while homing is under way
                if (phase == PH_IDLE)
                begin
                    saved_int   = lateral_int;
                    saved_dir   = dir_bits[1];
                    lateral_int = homing_int;
                    dir_bits[1] = home_dir_cfg;
                    en_bits[1]  = 1'b1;
                    run_bits    = 2'b10;
                    phase       = PH_APPROACH;
                end
            end
            MODE_ACK:
                pend_ev = EV_NONE;
            MODE_RESET_CNT:
            begin
                clr          = CLR_ALL;
                sp_fault     = 1'b0;
                lat_fault    = 1'b0;
                lat_es_fault = 1'b0;
            end
            default:
                ;
        endcase

        // Advance the homing machine by one step
        if (phase == PH_APPROACH)
        begin
            if (c.endstop_bits != 2'd0)
            begin
                run_bits[1]  = 1'b0;
                if (clr == CLR_NONE)
                    clr = CLR_LATERAL;
                lat_fault    = 1'b0;
                lat_es_fault = 1'b0;
                phase        = PH_HIT;
            end
        end
        else if (phase == PH_HIT)
        begin
            lateral_int = saved_int;
            dir_bits[1] = saved_dir;
            pend_ev     = EV_HOME;
            phase       = PH_IDLE;
        end
        else if (phase != PH_IDLE)
            phase = PH_IDLE;

        // Publish the flags and raise an endstop event outside homing
        if (c.publish)
        begin
            flags[0] = (phase != PH_IDLE);
            flags[1] = |run_bits;
            flags[2] = (c.endstop_bits != 2'd0);
            flags[3] = sp_fault | lat_fault;
            if (phase == PH_IDLE && lat_es_fault && pend_ev == EV_NONE)
                pend_ev = EV_ENDSTOP;
        end

        r.spindle_interval = spindle_int;
        r.lateral_interval = lateral_int;
        r.spindle_dir      = dir_bits[0];
        r.lateral_dir      = dir_bits[1];
        r.spindle_enable   = en_bits[0];
        r.lateral_enable   = en_bits[1];
        r.spindle_run      = run_bits[0];
        r.lateral_run      = run_bits[1];
        r.acked_command    = c.mode;
        r.state_flags      = flags;
        r.event_code       = pend_ev;
        r.clear_counters   = clr;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        n_fail++;
        if (n_fail <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic compare_result(input result_item_t got, input result_item_t want);
        check_field("spindle_interval", got.spindle_interval, want.spindle_interval);
        check_field("lateral_interval", got.lateral_interval, want.lateral_interval);
        check_field("spindle_dir", 32'(got.spindle_dir), 32'(want.spindle_dir));
        check_field("lateral_dir", 32'(got.lateral_dir), 32'(want.lateral_dir));
        check_field("spindle_enable", 32'(got.spindle_enable), 32'(want.spindle_enable));
        check_field("lateral_enable", 32'(got.lateral_enable), 32'(want.lateral_enable));
        check_field("spindle_run", 32'(got.spindle_run), 32'(want.spindle_run));
        check_field("lateral_run", 32'(got.lateral_run), 32'(want.lateral_run));
        check_field("acked_command", 32'(got.acked_command), 32'(want.acked_command));
        check_field("state_flags", 32'(got.state_flags), 32'(want.state_flags));
        check_field("event_code", 32'(got.event_code), 32'(want.event_code));
        check_field("clear_counters", 32'(got.clear_counters), 32'(want.clear_counters));
    endtask

    // Watch the three channels: configure, predict, then compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_int   = HOMING_INTERVAL_RST;
            home_dir_cfg = HOMING_DIRECTION_RST;
            phase        = PH_IDLE;
            saved_int    = '0;
            saved_dir    = 1'b0;
            spindle_int  = '0;
            lateral_int  = '0;
            dir_bits     = 2'b00;
            en_bits      = 2'b00;
            run_bits     = 2'b00;
            pend_ev      = EV_NONE;
            expected_results.delete();
            n_pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_HOMING_INTERVAL)
                    homing_int = cfg.data;
                else if (cfg.index == CFG_HOMING_DIRECTION)
                    home_dir_cfg = cfg.data[0];
            end
            if (cmd.valid && cmd.ready)
            begin
                seen_cmd = '{cmd.mode, cmd.spindle_interval_target,
                             cmd.lateral_interval_target, cmd.spindle_dir_target,
                             cmd.lateral_dir_target, cmd.enable_value, cmd.axis_select,
                             cmd.endstop_bits, cmd.spindle_fault, cmd.lateral_fault,
                             cmd.lateral_endstop_fault, cmd.publish};
                expected_results.push_back(predict_period(seen_cmd));
            end
            if (result.valid && result.ready)
            begin
                seen_res = '{result.spindle_interval, result.lateral_interval,
                             result.spindle_dir, result.lateral_dir, result.spindle_enable,
                             result.lateral_enable, result.spindle_run, result.lateral_run,
                             result.acked_command, result.state_flags, result.event_code,
                             result.clear_counters};
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with no command waiting");
                else
                begin
                    want_res = expected_results.pop_front();
                    compare_result(seen_res, want_res);
                end
            end
            n_pending = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/stepper_command_homing_supervisor_top_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, command stimulus, flow control and verdict for the supervisor.
module stepper_command_homing_supervisor_top_tb;
    import shs_pkg::*;

    localparam int PHASE_ITEMS      = 175;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int LIMIT_CYCLES     = 200000;
    localparam int DRAIN_CYCLES     = 4;
    localparam int TAIL_CYCLES      = 10;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   items_sent    = 0;
    int   cycle_count   = 0;
    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    logic long_hold_req = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left = 0;

    shs_cmd_if    cmd_ch();
    shs_result_if res_ch();
    shs_cfg_if    cfg_ch();

    stepper_command_homing_supervisor_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    homing_supervisor_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abandon a run that hangs
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // Drive result ready: random stalls, plus one long hold counted here
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_item_t make_command(input mode_t m, input logic [31:0] sp,
                                               input logic [31:0] lat, input logic [1:0] dirs,
                                               input logic en, input axis_t ax,
                                               input logic [1:0] es, input logic [2:0] faults,
                                               input logic pub);
        cmd_item_t c;
        c.mode                    = m;
        c.spindle_interval_target = sp;
        c.lateral_interval_target = lat;
        c.spindle_dir_target      = dirs[0];
        c.lateral_dir_target      = dirs[1];
        c.enable_value            = en;
        c.axis_select             = ax;
        c.endstop_bits            = es;
        c.spindle_fault           = faults[0];
        c.lateral_fault           = faults[1];
        c.lateral_endstop_fault   = faults[2];
        c.publish                 = pub;
        return c;
    endfunction

    function automatic cmd_item_t random_period(input mode_t m);
        return make_command(m, pick_interval(), pick_interval(), 2'($urandom_range(3)),
                            1'($urandom_range(1)), axis_t'($urandom_range(3)),
                            2'($urandom_range(3)), 3'($urandom_range(7)),
                            1'($urandom_range(1)));
    endfunction

    // Modes that may fall inside a homing run; estop now and then breaks it
    function automatic mode_t quiet_mode();
        case ($urandom_range(9))
            4: return MODE_ACK;
            5: return MODE_UNKNOWN;
            6: return MODE_RESET_CNT;
            7: return MODE_SET_SPEED;
            8: return MODE_HOME;
            9: return MODE_ESTOP;
            default: return MODE_NONE;
        endcase
    endfunction

    // Offer one command after a random gap and hold it until accepted
    task automatic send_command(input cmd_item_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.mode                    <= c.mode;
        cmd_ch.spindle_interval_target <= c.spindle_interval_target;
        cmd_ch.lateral_interval_target <= c.lateral_interval_target;
        cmd_ch.spindle_dir_target      <= c.spindle_dir_target;
        cmd_ch.lateral_dir_target      <= c.lateral_dir_target;
        cmd_ch.enable_value            <= c.enable_value;
        cmd_ch.axis_select             <= c.axis_select;
        cmd_ch.endstop_bits            <= c.endstop_bits;
        cmd_ch.spindle_fault           <= c.spindle_fault;
        cmd_ch.lateral_fault           <= c.lateral_fault;
        cmd_ch.lateral_endstop_fault   <= c.lateral_endstop_fault;
        cmd_ch.publish                 <= c.publish;
        cmd_ch.valid                   <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every result is back, then let the pipeline settle
    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write both homing registers back to back
    task automatic program_homing(input logic [31:0] interval, input logic dir);
        cfg_ch.index <= CFG_HOMING_INTERVAL;
        cfg_ch.data  <= interval;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.index <= CFG_HOMING_DIRECTION;
        cfg_ch.data  <= {31'd0, dir};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One well-formed homing run with random content around it
    task automatic run_homing_cycle();
        cmd_item_t c;
        int        n_wait;
        n_wait = $urandom_range(4);
        if ($urandom_range(1))
        begin
            c              = random_period(MODE_ENABLE);
            c.enable_value = 1'b1;
            c.axis_select  = $urandom_range(1) ? SEL_BOTH : SEL_LATERAL;
            send_command(c);
        end
        if ($urandom_range(1))
        begin
            c              = random_period(MODE_SET_SPEED);
            c.endstop_bits = 2'd0;
            send_command(c);
        end
        c = random_period(MODE_HOME);
        if ($urandom_range(3) != 0)
            c.endstop_bits = 2'd0;
        send_command(c);
        repeat (n_wait)
        begin
            c              = random_period(quiet_mode());
            c.endstop_bits = 2'd0;
            send_command(c);
        end
        c              = random_period(quiet_mode());
        c.endstop_bits = 2'($urandom_range(3, 1));
        send_command(c);
        send_command(random_period(quiet_mode()));
        if ($urandom_range(1))
            send_command(random_period(MODE_ACK));
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 60)
                run_homing_cycle();
            else
                send_command(random_period(mode_t'($urandom_range(7))));
        end
    endtask

    task automatic run_directed();
        send_command(make_command(MODE_NONE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b1));
        send_command(make_command(MODE_SET_SPEED, '1, '1, 2'b11, 1'b0, SEL_SPINDLE, 2'd0,
                                  3'b000, 1'b1));
        send_command(make_command(MODE_ENABLE, 0, 0, 2'b00, 1'b1, SEL_BOTH, 2'd0, 3'b000,
                                  1'b0));
        send_command(make_command(MODE_SET_SPEED, '1, 1, 2'b11, 1'b0, SEL_SPINDLE, 2'd0,
                                  3'b000, 1'b1));
        send_command(make_command(MODE_SET_SPEED, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0,
                                  3'b000, 1'b1));
        // Axis none: acknowledged, nothing changes
        send_command(make_command(MODE_ENABLE, 0, 0, 2'b00, 1'b0, SEL_NONE, 2'd0, 3'b000,
                                  1'b0));
        send_command(make_command(MODE_SET_SPEED, 5, 7, 2'b00, 1'b0, SEL_SPINDLE, 2'd0,
                                  3'b000, 1'b1));
        send_command(make_command(MODE_ENABLE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b1));
        send_command(make_command(MODE_HOME, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b1));
        // Second start while homing is only acknowledged
        send_command(make_command(MODE_HOME, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b111,
                                  1'b1));
        send_command(make_command(MODE_NONE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd3, 3'b111,
                                  1'b1));
        send_command(make_command(MODE_NONE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b1));
        send_command(make_command(MODE_NONE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b100,
                                  1'b1));
        send_command(make_command(MODE_ACK, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b0));
        // Endstop event outside homing, with a fault flagged
        send_command(make_command(MODE_NONE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b101,
                                  1'b1));
        send_command(make_command(MODE_RESET_CNT, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0,
                                  3'b111, 1'b1));
        send_command(make_command(MODE_ACK, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b100,
                                  1'b1));
        send_command(make_command(MODE_HOME, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b0));
        // Counter reset and endstop hit in the same period
        send_command(make_command(MODE_RESET_CNT, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd2,
                                  3'b111, 1'b1));
        send_command(make_command(MODE_NONE, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b1));
        send_command(make_command(MODE_HOME, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd0, 3'b000,
                                  1'b0));
        // Estop mid-homing: no restore of the saved lateral values
        send_command(make_command(MODE_ESTOP, 0, 0, 2'b00, 1'b0, SEL_SPINDLE, 2'd1, 3'b010,
                                  1'b1));
        send_command(make_command(MODE_UNKNOWN, '1, '1, 2'b11, 1'b1, SEL_NONE, 2'd3, 3'b111,
                                  1'b1));
        send_command(make_command(MODE_ENABLE, 0, 0, 2'b00, 1'b1, SEL_LATERAL, 2'd0, 3'b000,
                                  1'b0));
        send_command(make_command(MODE_ENABLE, 0, 0, 2'b00, 1'b0, SEL_BOTH, 2'd0, 3'b000,
                                  1'b1));
    endtask

    // Stimulus: reset, then four configuration phases with their own flow control
    initial
    begin
        logic [31:0] cfg_interval [4];
        logic        cfg_dir      [4];
        int          src_pct      [4];
        int          snk_pct      [4];
        cfg_interval = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1};
        cfg_dir      = '{1'b0, 1'b1, 1'b0, 1'b1};
        src_pct      = '{0, 45, 0, 10};
        snk_pct      = '{0, 0, 45, 10};

        rst_n                          = 1'b0;
        cmd_ch.valid                   = 1'b0;
        cmd_ch.mode                    = MODE_NONE;
        cmd_ch.spindle_interval_target = '0;
        cmd_ch.lateral_interval_target = '0;
        cmd_ch.spindle_dir_target      = 1'b0;
        cmd_ch.lateral_dir_target      = 1'b0;
        cmd_ch.enable_value            = 1'b0;
        cmd_ch.axis_select             = SEL_SPINDLE;
        cmd_ch.endstop_bits            = 2'd0;
        cmd_ch.spindle_fault           = 1'b0;
        cmd_ch.lateral_fault           = 1'b0;
        cmd_ch.lateral_endstop_fault   = 1'b0;
        cmd_ch.publish                 = 1'b0;
        cfg_ch.valid                   = 1'b0;
        cfg_ch.index                   = CFG_HOMING_INTERVAL;
        cfg_ch.data                    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        for (int p = 0; p < 4; p++)
        begin
            if (p == 2)
                cfg_interval[2] = $urandom;
            wait_drain();
            program_homing(cfg_interval[p], cfg_dir[p]);
            src_idle_pct  = src_pct[p];
            snk_stall_pct = snk_pct[p];
            if (p == 0)
            begin
                run_directed();
                // Hold the result side off while commands keep coming
                long_hold_req = 1'b1;
            end
            if (p == 2)
            begin
                run_random(PHASE_ITEMS / 2);
                wait_drain();
                run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                run_random(PHASE_ITEMS);
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/shs_pkg.sv
rtl/core/shs_channels.sv
rtl/core/stepper_command_homing_supervisor_top.sv
tb/sv/homing_supervisor_checker.sv
tb/sv/stepper_command_homing_supervisor_top_tb.sv
